[design/first_fit_cell_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_unit_macros
// Assertion shorthands for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CELL_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_CELL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FFCA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication, disabled during reset
`define FFCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

[design/ffca_pkg.sv]
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types, codes and sizes of the first-fit cell allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

	localparam int MEM_CELLS   = 128;
	localparam int HANDLE_BITS = 16;

	localparam int IDX_W = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
	localparam int CNT_W = $clog2(MEM_CELLS + 1);
	localparam int CTR_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_ERASE  = 2'd1;
	localparam logic [1:0] ACT_DEFRAG = 2'd2;
	// spare action code, taken and dropped without a result
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         amount;
		logic signed [31:0] handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] new_handle;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ALLOC_SCAN,
		OP_FILL,
		OP_ERASE,
		OP_COMPACT,
		OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		logic       load;
		dp_op_t     op;
		logic       rsp_load;
		logic [1:0] rsp_status;
	} cmd_t;

	typedef struct packed {
		logic alloc_bad;
		logic erase_bad;
		logic hit;
		logic scan_done;
		logic fill_done;
		logic clear_done;
		logic found;
		logic rsp_free;
	} stat_t;

	typedef struct packed {
		logic                   rd_en;
		logic [IDX_W-1:0]       rd_addr;
		logic                   wr_en;
		logic [IDX_W-1:0]       wr_addr;
		logic [HANDLE_BITS-1:0] wr_data;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_SCAN,
		S_ALLOC_FILL,
		S_ERASE_SCAN,
		S_DEFRAG_SCAN,
		S_DEFRAG_CLEAR,
		S_RESP_OK,
		S_RESP_FAIL,
		S_RESP_ILLEGAL
	} state_t;

endpackage

`default_nettype wire

[design/ffca_cell_store.sv]
// ----------------------------------------------------------------------------
// ffca_cell_store
// Owner memory of the cell pool with one valid flop per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffca_cell_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ffca_pkg::mem_req_t              mreq,
	output logic [ffca_pkg::HANDLE_BITS-1:0] rd_data
);
	import ffca_pkg::*;

	logic [HANDLE_BITS-1:0] cells_q [MEM_CELLS];
	logic [MEM_CELLS-1:0]   valid_q;
	logic [HANDLE_BITS-1:0] raw_s1;
	logic                   valid_s1;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			cells_q[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			raw_s1 <= cells_q[mreq.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (mreq.wr_en) begin
				valid_q[mreq.wr_addr] <= 1'b1;
			end
			if (mreq.rd_en) begin
				valid_s1 <= valid_q[mreq.rd_addr];
			end
		end
	end

	// a cell never written since reset reads as free
	assign rd_data = valid_s1 ? raw_s1 : '0;

endmodule

`default_nettype wire

[design/ffca_datapath.sv]
// ----------------------------------------------------------------------------
// ffca_datapath
// Scan counters, run tracking, write steering and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffca_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [7:0]                      cfg_wr_data,
	input  ffca_pkg::req_t                  req,
	input  ffca_pkg::cmd_t                  cmd,
	output ffca_pkg::stat_t                 stat,
	output ffca_pkg::mem_req_t              mreq,
	input  logic [ffca_pkg::HANDLE_BITS-1:0] cell_rd_data,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output ffca_pkg::rsp_t                  rsp
);
	import ffca_pkg::*;

	logic [7:0]             pool_size_q;
	logic [HANDLE_BITS-1:0] next_handle_q;
	logic [7:0]             amount_q;
	logic [31:0]            handle_q;
	logic [CTR_W-1:0]       rd_ptr_q;
	logic [CTR_W-1:0]       wr_ptr_q;
	logic [CTR_W-1:0]       run_q;
	logic [CTR_W-1:0]       fill_cnt_q;
	logic                   found_q;
	logic                   rd_v_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [CTR_W-1:0] pool_ext;
	logic [CTR_W-1:0] n_cells;
	logic [CTR_W-1:0] amount_ext;
	logic             rd_more;
	logic             scanning;
	logic             issue;
	logic             cell_free;
	logic             erase_match;
	logic             run_hit;
	logic             wr_step;

	assign pool_ext   = CTR_W'(pool_size_q);
	assign n_cells    = (pool_ext < CTR_W'(MEM_CELLS)) ? pool_ext : CTR_W'(MEM_CELLS);
	assign amount_ext = CTR_W'(amount_q);

	assign rd_more  = rd_ptr_q < n_cells;
	assign scanning = (cmd.op == OP_ALLOC_SCAN) || (cmd.op == OP_ERASE) ||
	                  (cmd.op == OP_COMPACT);
	assign issue    = scanning && rd_more;

	assign cell_free   = (cell_rd_data == '0);
	assign erase_match = (32'(cell_rd_data) == handle_q);
	assign run_hit     = rd_v_s1 && cell_free && ((run_q + CTR_W'(1)) == amount_ext);

	always_comb begin
		mreq.rd_en   = issue;
		mreq.rd_addr = rd_ptr_q[IDX_W-1:0];
		mreq.wr_en   = 1'b0;
		mreq.wr_addr = wr_ptr_q[IDX_W-1:0];
		mreq.wr_data = '0;
		wr_step      = 1'b0;
		unique case (cmd.op)
			OP_FILL: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_data = next_handle_q;
			end
			OP_ERASE: begin
				if (rd_v_s1 && erase_match) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = addr_s1;
				end
			end
			OP_COMPACT: begin
				// move a used cell down to the write pointer
				if (rd_v_s1 && !cell_free) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_data = cell_rd_data;
					wr_step      = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (wr_ptr_q < n_cells) begin
					mreq.wr_en = 1'b1;
					wr_step    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.alloc_bad  = (amount_q == 8'd0) || (amount_ext > n_cells) ||
	                         (next_handle_q == '0);
	assign stat.erase_bad  = (handle_q == 32'd0) || handle_q[31];
	assign stat.hit        = run_hit;
	assign stat.scan_done  = !rd_more && !rd_v_s1;
	assign stat.fill_done  = (fill_cnt_q + CTR_W'(1)) == amount_ext;
	assign stat.clear_done = !(wr_ptr_q < n_cells);
	assign stat.found      = found_q;
	assign stat.rsp_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amount_q <= req.amount;
			handle_q <= $unsigned(req.handle);
		end
		addr_s1 <= rd_ptr_q[IDX_W-1:0];
		if (cmd.rsp_load) begin
			rsp_q.status     <= cmd.rsp_status;
			rsp_q.new_handle <= (cmd.rsp_status == ST_OK) ? 16'(next_handle_q) : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q   <= 8'd128;
			next_handle_q <= HANDLE_BITS'(1);
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			run_q         <= '0;
			fill_cnt_q    <= '0;
			found_q       <= 1'b0;
			rd_v_s1       <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pool_size_q <= cfg_wr_data;
			end
			rd_v_s1 <= issue;

			if (cmd.load) begin
				rd_ptr_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CTR_W'(1);
			end

			if (cmd.load) begin
				run_q <= '0;
			end else if (cmd.op == OP_ALLOC_SCAN && rd_v_s1) begin
				run_q <= cell_free ? run_q + CTR_W'(1) : '0;
			end

			// a hit latches the run start for the fill
			if (cmd.load) begin
				wr_ptr_q <= '0;
			end else if (cmd.op == OP_ALLOC_SCAN && run_hit) begin
				wr_ptr_q <= CTR_W'(addr_s1) + CTR_W'(1) - amount_ext;
			end else if (cmd.op == OP_FILL || wr_step) begin
				wr_ptr_q <= wr_ptr_q + CTR_W'(1);
			end

			if (cmd.load) begin
				fill_cnt_q <= '0;
			end else if (cmd.op == OP_FILL) begin
				fill_cnt_q <= fill_cnt_q + CTR_W'(1);
			end

			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.op == OP_ERASE && rd_v_s1 && erase_match) begin
				found_q <= 1'b1;
			end

			if (cmd.rsp_load && cmd.rsp_status == ST_OK) begin
				next_handle_q <= next_handle_q + HANDLE_BITS'(1);
			end

			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[design/ffca_ctrl.sv]
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer of the allocator: one request at a time, scan then write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      action,
	input  ffca_pkg::stat_t stat,
	output ffca_pkg::cmd_t  cmd,
	output logic            req_stall
);
	import ffca_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (action)
						ACT_ALLOC:  state_d = S_ALLOC_SCAN;
						ACT_ERASE:  state_d = S_ERASE_SCAN;
						ACT_DEFRAG: state_d = S_DEFRAG_SCAN;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC_SCAN: begin
				priority if (stat.alloc_bad) begin
					state_d = S_RESP_FAIL;
				end else if (stat.hit) begin
					state_d = S_ALLOC_FILL;
				end else if (stat.scan_done) begin
					state_d = S_RESP_FAIL;
				end
			end
			S_ALLOC_FILL: begin
				if (stat.fill_done) begin
					state_d = S_RESP_OK;
				end
			end
			S_ERASE_SCAN: begin
				priority if (stat.erase_bad) begin
					state_d = S_RESP_ILLEGAL;
				end else if (stat.scan_done) begin
					state_d = stat.found ? S_IDLE : S_RESP_ILLEGAL;
				end
			end
			S_DEFRAG_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_DEFRAG_CLEAR;
				end
			end
			S_DEFRAG_CLEAR: begin
				if (stat.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_RESP_OK, S_RESP_FAIL, S_RESP_ILLEGAL: begin
				// hold until the response register has room
				if (stat.rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load       = 1'b0;
		cmd.op         = OP_NONE;
		cmd.rsp_load   = 1'b0;
		cmd.rsp_status = ST_OK;
		req_stall      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_ALLOC_SCAN:   cmd.op = OP_ALLOC_SCAN;
			S_ALLOC_FILL:   cmd.op = OP_FILL;
			S_ERASE_SCAN:   cmd.op = OP_ERASE;
			S_DEFRAG_SCAN:  cmd.op = OP_COMPACT;
			S_DEFRAG_CLEAR: cmd.op = OP_CLEAR;
			S_RESP_OK: begin
				cmd.rsp_load   = stat.rsp_free;
				cmd.rsp_status = ST_OK;
			end
			S_RESP_FAIL: begin
				cmd.rsp_load   = stat.rsp_free;
				cmd.rsp_status = ST_FAIL;
			end
			S_RESP_ILLEGAL: begin
				cmd.rsp_load   = stat.rsp_free;
				cmd.rsp_status = ST_ILLEGAL;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[design/first_fit_cell_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_unit: first-fit contiguous cell allocator
// Cells are scanned through the single read port of the cell memory (one cell
//   a cycle): alloc scans then, on a fit, fills, erase scans, defragment compacts
//   then clears the tail; a stalled result adds its wait. A result shows in the
//   same cycle that the unit returns to idle and takes the next request. Reset
//   is asynchronous: all cells read free at once through per-cell valid flops,
//   so no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_cell_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [7:0]     cfg_wr_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffca_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffca_pkg::rsp_t rsp
);
	import ffca_pkg::*;

	cmd_t                   cmd;
	stat_t                  stat;
	mem_req_t               mreq;
	logic [HANDLE_BITS-1:0] cell_rd_data;

	ffca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	ffca_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req          (req),
		.cmd          (cmd),
		.stat         (stat),
		.mreq         (mreq),
		.cell_rd_data (cell_rd_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

	ffca_cell_store u_cell_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mreq    (mreq),
		.rd_data (cell_rd_data)
	);

endmodule

`default_nettype wire

[design/ffca_checker.sv]
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_cell_allocator_unit_macros.svh"

module ffca_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ffca_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ffca_pkg::rsp_t rsp
);
	import ffca_pkg::*;

	// a stalled response holds
	`FFCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// a real request keeps the unit busy for at least the next cycle
	`FFCA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && req.action != ACT_UNUSED, req_stall)
	// failures carry no handle
	`FFCA_ASSERT_NOW(a_fail_no_handle, rsp_valid && rsp.status != ST_OK, rsp.new_handle == 16'd0)
	// a granted handle is never zero
	`FFCA_ASSERT_NOW(a_ok_handle, rsp_valid && rsp.status == ST_OK, rsp.new_handle != 16'd0)

endmodule

bind first_fit_cell_allocator_unit ffca_checker u_ffca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

[tb/first_fit_cell_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_unit_tb
// Self-checking bench for the first-fit cell allocator. A queue-fed driver
// offers requests, and a clocked monitor checks every result against a local
// model of the cell pool. The run moves through several pool sizes and ends
// on a one-cell pool with no idling.
// ----------------------------------------------------------------------------

module first_fit_cell_allocator_unit_tb;

	import ffca_pkg::*;

	localparam int     CLK_HALF     = 5;
	localparam int     DRAIN_CYCLES = 300;
	localparam int     LONG_HOLD    = 400;
	localparam int     HOLD_AFTER   = 150;
	localparam int     QUEUE_AHEAD  = 2;
	localparam longint TIMEOUT_NS   = 100_000_000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       req_valid   = 1'b0;
	logic       req_stall;
	req_t       req         = '0;
	logic       rsp_valid;
	logic       rsp_stall   = 1'b0;
	rsp_t       rsp;

	// pool model
	logic [15:0] cell_map [MEM_CELLS];
	logic [15:0] next_id;
	logic [7:0]  pool_len;

	rsp_t expected_rsps [$];
	req_t pend_reqs [$];

	int req_offered = 0;
	int req_accepts = 0;
	int n_alloc     = 0;
	int n_erase     = 0;
	int n_defrag    = 0;
	int n_unused    = 0;
	int n_rsp       = 0;
	int n_granted   = 0;
	int n_refused   = 0;
	int n_illegal   = 0;
	int errors      = 0;
	bit quiet       = 1'b0;

	int phase_pool [8] = '{1, 255, 0, 37, 128, 5, 200, 64};
	int phase_len  [8] = '{40, 300, 60, 300, 400, 150, 250, 400};

	first_fit_cell_allocator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	// Advance the pool model by one request and queue the result it causes.
	function automatic void apply_request(input req_t r);
		int   span;
		int   start;
		int   j;
		int   w;
		bit   found;
		rsp_t want;
		span = (pool_len < MEM_CELLS) ? int'(pool_len) : MEM_CELLS;
		want = '0;
		case (r.action)
			ACT_ALLOC: begin
				n_alloc++;
				want.status = ST_FAIL;
				if (r.amount != 0 && r.amount <= span && next_id != 0) begin
					for (start = 0; start + r.amount <= span && want.status == ST_FAIL;
							start++) begin
						found = 1'b1;
						for (j = start; j < start + r.amount; j++)
							if (cell_map[j] != 0)
								found = 1'b0;
						if (found) begin
							for (j = start; j < start + r.amount; j++)
								cell_map[j] = next_id;
							want.status     = ST_OK;
							want.new_handle = next_id;
							next_id         = next_id + 16'd1;
						end
					end
				end
				expected_rsps.push_back(want);
			end
			ACT_ERASE: begin
				n_erase++;
				found = 1'b0;
				if (r.handle > 0) begin
					for (j = 0; j < span; j++) begin
						if ({16'd0, cell_map[j]} == $unsigned(r.handle)) begin
							cell_map[j] = '0;
							found       = 1'b1;
						end
					end
				end
				if (!found) begin
					want.status = ST_ILLEGAL;
					expected_rsps.push_back(want);
				end
			end
			ACT_DEFRAG: begin
				n_defrag++;
				w = 0;
				for (j = 0; j < span; j++) begin
					if (cell_map[j] != 0) begin
						cell_map[w] = cell_map[j];
						w++;
					end
				end
				for (j = w; j < span; j++)
					cell_map[j] = '0;
			end
			default: begin
				n_unused++;
			end
		endcase
	endfunction

	task automatic check_result(input rsp_t got);
		rsp_t want;
		n_rsp++;
		if (expected_rsps.size() == 0) begin
			report_mismatch($sformatf("unexpected result status %0d handle %0d",
				got.status, got.new_handle));
			return;
		end
		want = expected_rsps.pop_front();
		case (want.status)
			ST_OK:   n_granted++;
			ST_FAIL: n_refused++;
			default: n_illegal++;
		endcase
		if (got.status !== want.status)
			report_mismatch($sformatf("result %0d status %0d, want %0d",
				n_rsp, got.status, want.status));
		if (got.new_handle !== want.new_handle)
			report_mismatch($sformatf("result %0d new_handle %0d, want %0d",
				n_rsp, got.new_handle, want.new_handle));
	endtask

	// monitor and predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int c = 0; c < MEM_CELLS; c++)
				cell_map[c] = '0;
			next_id  = 16'd1;
			pool_len = 8'd128;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (req_valid && !req_stall) begin
				apply_request(req);
				req_accepts++;
			end
			if (cfg_wr_en)
				pool_len = cfg_wr_data;
		end
	end

	// request driver
	int gap_left  = 0;
	int gap_calm  = 0;
	always @(negedge clk) begin
		req_t nxt_req;
		bit   nxt_valid;
		nxt_req   = req;
		nxt_valid = req_valid;
		if (arst_n && (!req_valid || req_accepts == req_offered)) begin
			nxt_valid = 1'b0;
			if (!quiet && gap_left == 0) begin
				if (gap_calm > 0)
					gap_calm--;
				else if ($urandom_range(0, 9) == 0)
					gap_left = $urandom_range(1, 19);
				else if ($urandom_range(0, 63) == 0)
					gap_calm = $urandom_range(100, 400);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_reqs.size() > 0) begin
				nxt_req   = pend_reqs.pop_front();
				nxt_valid = 1'b1;
				req_offered++;
			end
		end
		req_valid <= nxt_valid;
		req       <= nxt_req;
	end

	// result receiver
	int  stall_left = 0;
	int  stall_calm = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;
	always @(negedge clk) begin
		bit stall_nxt;
		stall_nxt = 1'b0;
		if (arst_n) begin
			// hold off once for a long stretch so the block backs up
			if (!hold_done && n_rsp >= HOLD_AFTER) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (!quiet && stall_left == 0 && hold_left == 0) begin
				if (stall_calm > 0)
					stall_calm--;
				else if ($urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 19);
				else if ($urandom_range(0, 63) == 0)
					stall_calm = $urandom_range(100, 400);
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_nxt = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_nxt = 1'b1;
			end
		end
		rsp_stall <= stall_nxt;
	end

	function automatic req_t make_req(input logic [1:0] act, input logic [7:0] amt,
			input logic [31:0] hnd);
		req_t r;
		r.action = act;
		r.amount = amt;
		r.handle = hnd;
		return r;
	endfunction

	// Keep the generator close behind the model so erase targets stay live.
	task automatic queue_req(input req_t r);
		while (pend_reqs.size() >= QUEUE_AHEAD)
			@(negedge clk);
		pend_reqs.push_back(r);
	endtask

	function automatic req_t random_request();
		req_t r;
		int   pick;
		int   slot;
		r        = '0;
		r.amount = $urandom_range(1, 12);
		r.handle = $urandom;
		pick     = $urandom_range(0, 99);
		if (pick < 50) begin
			r.action = ACT_ALLOC;
			case ($urandom_range(0, 9))
				0:       r.amount = $urandom_range(0, 255);
				1:       r.amount = $urandom_range(13, 128);
				default: ;
			endcase
		end else if (pick < 85) begin
			r.action = ACT_ERASE;
			slot     = $urandom_range(0, MEM_CELLS - 1);
			case ($urandom_range(0, 9))
				0:       r.handle = $urandom;
				1:       r.handle = 32'd0;
				2:       r.handle = $urandom | 32'h8000_0000;
				3:       r.handle = {16'd0, 16'(next_id - 16'd1)};
				default: begin
					if (cell_map[slot] != 0)
						r.handle = {16'd0, cell_map[slot]};
					else
						r.handle = {16'd0, 16'(next_id - 16'd1)};
				end
			endcase
		end else if (pick < 95) begin
			r.action = ACT_DEFRAG;
		end else begin
			r.action = ACT_UNUSED;
		end
		return r;
	endfunction

	// Wait until the block has gone quiet, including requests without a result.
	task automatic settle();
		while (pend_reqs.size() != 0 || req_accepts != req_offered ||
				expected_rsps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_pool(input logic [7:0] cells);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cells;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		#TIMEOUT_NS;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on the reset pool of 128 cells
		queue_req(make_req(ACT_ALLOC,  8'd1,   32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd128, 32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd0,   32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd255, 32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd127, 32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd1,   32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd1));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'hFFFF_FFFF));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'h8000_0000));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'h7FFF_FFFF));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd1));
		queue_req(make_req(ACT_UNUSED, 8'hFF,  32'hFFFF_FFFF));
		queue_req(make_req(ACT_DEFRAG, 8'd0,   32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd1,   32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd2));
		queue_req(make_req(ACT_ALLOC,  8'd128, 32'd0));
		queue_req(make_req(ACT_DEFRAG, 8'd0,   32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd127, 32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd3));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd4));
		queue_req(make_req(ACT_ALLOC,  8'd128, 32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1,   32'd5));
		queue_req(make_req(ACT_ALLOC,  8'd3,   32'd0));
		// low half matches a live handle, upper half does not
		queue_req(make_req(ACT_ERASE,  8'd1,   32'h0001_0006));

		for (int k = 0; k < 8; k++) begin
			set_pool(8'(phase_pool[k]));
			for (int i = 0; i < phase_len[k]; i++)
				queue_req(random_request());
		end

		// finish on a one-cell pool, no idling from here on
		quiet = 1'b1;
		set_pool(8'd1);
		if (cell_map[0] != 0)
			queue_req(make_req(ACT_ERASE, 8'd1, {16'd0, cell_map[0]}));
		queue_req(make_req(ACT_ALLOC,  8'd1, 32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd0, 32'd0));
		queue_req(make_req(ACT_ERASE,  8'd1, 32'd65535));
		queue_req(make_req(ACT_DEFRAG, 8'd0, 32'd0));
		queue_req(make_req(ACT_ALLOC,  8'd1, 32'd0));
		settle();

		$display("run: %0d requests (%0d alloc, %0d erase, %0d compact, %0d unused code)",
			req_accepts, n_alloc, n_erase, n_defrag, n_unused);
		$display("run: %0d results (%0d granted, %0d refused, %0d illegal erase), %0d errors",
			n_rsp, n_granted, n_refused, n_illegal, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
